// File: src/kmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants for the spanning forest weight engine.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int unsigned TREE_W       = 22;
    localparam int unsigned VCOUNT_W     = 7;
    localparam logic [6:0]  VCOUNT_RESET = 7'd64;

    typedef struct packed {
        logic [5:0]         edge_src;
        logic [5:0]         edge_dst;
        logic signed [15:0] edge_weight;
        logic               last_edge;
    } edge_in_t;

    typedef struct packed {
        logic signed [21:0] tree_weight;
        logic               edges_dropped_full;
        logic               edges_dropped_bad;
    } forest_out_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_SCAN,
        S_RDA,
        S_CHKA,
        S_RDB,
        S_CHKB,
        S_LINK,
        S_GROW,
        S_DONE
    } kmst_state_t;

endpackage

// File: src/kmst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/kruskal_mst_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_mst_weight
// Minimum spanning forest weight over a loaded edge list (Kruskal, union-find).
// ----------------------------------------------------------------------------
// Edges load at one per cycle into the edge RAM while no run is active. The
// transaction flagged last_edge starts the run: a sweep over all MAX_VERTICES
// entries resets the union-find RAM, then each round scans all stored edges
// to pick the next one in (weight, slot) order and walks both endpoints to
// their roots (depth at most log2 of MAX_VERTICES with union by size),
// merging them in the S_LINK and S_GROW states when the roots differ. The
// scan over the edge RAM read port dominates the run time.
// Input is stalled during a run; one result is then posted in an output
// register while the next graph may already load.
module kruskal_mst_weight #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  kmst_pkg::edge_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output kmst_pkg::forest_out_t out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [6:0]            cfg_data
);

    localparam int VB     = $clog2(MAX_VERTICES);
    localparam int SZ_W   = $clog2(MAX_VERTICES + 1);
    localparam int EA     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FILL_W = $clog2(MAX_EDGES + 1);
    localparam int CMP_W  = (VB + 1 > 7) ? VB + 1 : 7;
    localparam int EW     = 2 * VB + WEIGHT_BITS;
    localparam int UW     = VB + SZ_W;
    localparam int ACC_W  = WEIGHT_BITS + FILL_W + 1;
    localparam int SW     = (ACC_W > kmst_pkg::TREE_W) ? ACC_W : kmst_pkg::TREE_W;
    localparam logic signed [SW-1:0] SUM_MAX = SW'(2097151);
    localparam logic signed [SW-1:0] SUM_MIN = -SW'(2097152);

    kmst_pkg::kmst_state_t state_reg, state_next;

    logic [6:0]               vcount_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic                     drop_full_reg, drop_bad_reg;
    logic [VB-1:0]            init_reg;
    logic [FILL_W-1:0]        scan_reg;
    logic                     rd_vld_reg;
    logic [EA-1:0]            rd_idx_reg;
    logic                     found_reg, have_prev_reg;
    logic signed [WEIGHT_BITS-1:0] best_w_reg, prev_w_reg;
    logic [EA-1:0]            best_i_reg, prev_i_reg;
    logic [VB-1:0]            best_src_reg, best_dst_reg;
    logic [VB-1:0]            cur_reg, ra_reg, child_reg, root_reg;
    logic [SZ_W-1:0]          sa_reg, nsize_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    kmst_pkg::forest_out_t    out_data_reg;

    // edge RAM
    logic            e_we;
    logic [EA-1:0]   e_waddr, e_raddr;
    logic [EW-1:0]   e_wdata, e_rdata;
    // union-find RAM: {parent, size}
    logic            u_we;
    logic [VB-1:0]   u_waddr;
    logic [UW-1:0]   u_wdata, u_rdata;

    kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    kmst_ram #(.WIDTH(UW), .DEPTH(MAX_VERTICES)) u_uf_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (cur_reg),
        .rdata (u_rdata)
    );

    // input decode
    logic                          in_acc, scan_rd, round_end;
    logic [CMP_W-1:0]              limit, src_ext, dst_ext;
    logic                          bad, full;
    logic signed [WEIGHT_BITS-1:0] in_w;
    logic [VB-1:0]                 rd_src, rd_dst, par;
    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic [SZ_W-1:0]               sz;
    logic                          cand_ok, same_root;
    logic signed [SW-1:0]          acc_ext;
    logic signed [kmst_pkg::TREE_W-1:0] sat_sum;

    always_comb
    begin
        in_acc  = in_valid && !in_stall;
        limit   = (CMP_W'(vcount_reg) < CMP_W'(MAX_VERTICES)) ?
                  CMP_W'(vcount_reg) : CMP_W'(MAX_VERTICES);
        src_ext = CMP_W'(in_data.edge_src);
        dst_ext = CMP_W'(in_data.edge_dst);
        bad     = (src_ext >= limit) || (dst_ext >= limit);
        full    = (fill_reg >= FILL_W'(MAX_EDGES));
        in_w    = WEIGHT_BITS'(in_data.edge_weight);

        scan_rd   = (state_reg == kmst_pkg::S_SCAN) && (scan_reg < fill_reg);
        round_end = (state_reg == kmst_pkg::S_SCAN) && !scan_rd && !rd_vld_reg;

        rd_src = e_rdata[EW-1 -: VB];
        rd_dst = e_rdata[WEIGHT_BITS +: VB];
        rd_w   = e_rdata[WEIGHT_BITS-1:0];
        // next edge: above the last pick, below the best so far
        cand_ok = (!have_prev_reg || rd_w > prev_w_reg ||
                   (rd_w == prev_w_reg && rd_idx_reg > prev_i_reg)) &&
                  (!found_reg || rd_w < best_w_reg ||
                   (rd_w == best_w_reg && rd_idx_reg < best_i_reg));

        par       = u_rdata[UW-1 -: VB];
        sz        = u_rdata[SZ_W-1:0];
        same_root = (cur_reg == ra_reg);

        acc_ext = SW'(acc_reg);
        if (acc_ext > SUM_MAX)
            sat_sum = kmst_pkg::TREE_W'(SUM_MAX);
        else if (acc_ext < SUM_MIN)
            sat_sum = kmst_pkg::TREE_W'(SUM_MIN);
        else
            sat_sum = kmst_pkg::TREE_W'(acc_ext);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmst_pkg::S_LOAD:
                if (in_acc && in_data.last_edge)
                    state_next = kmst_pkg::S_INIT;
            kmst_pkg::S_INIT:
                if (init_reg == VB'(MAX_VERTICES - 1))
                    state_next = kmst_pkg::S_SCAN;
            kmst_pkg::S_SCAN:
                if (round_end)
                    state_next = found_reg ? kmst_pkg::S_RDA : kmst_pkg::S_DONE;
            kmst_pkg::S_RDA:
                state_next = kmst_pkg::S_CHKA;
            kmst_pkg::S_CHKA:
                state_next = (par == cur_reg) ? kmst_pkg::S_RDB : kmst_pkg::S_RDA;
            kmst_pkg::S_RDB:
                state_next = kmst_pkg::S_CHKB;
            kmst_pkg::S_CHKB:
                if (par != cur_reg)
                    state_next = kmst_pkg::S_RDB;
                else if (same_root)
                    state_next = kmst_pkg::S_SCAN;
                else
                    state_next = kmst_pkg::S_LINK;
            kmst_pkg::S_LINK:
                state_next = kmst_pkg::S_GROW;
            kmst_pkg::S_GROW:
                state_next = kmst_pkg::S_SCAN;
            kmst_pkg::S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = kmst_pkg::S_LOAD;
            default:
                state_next = kmst_pkg::S_LOAD;
        endcase
    end

    // memory controls
    always_comb
    begin
        in_stall = (state_reg != kmst_pkg::S_LOAD);
        e_we     = in_acc && !bad && !full;
        e_waddr  = fill_reg[EA-1:0];
        e_wdata  = {src_ext[VB-1:0], dst_ext[VB-1:0], in_w};
        e_raddr  = scan_reg[EA-1:0];
        u_we     = 1'b0;
        u_waddr  = init_reg;
        u_wdata  = {init_reg, SZ_W'(1)};
        unique case (state_reg)
            kmst_pkg::S_INIT:
                u_we = 1'b1;
            kmst_pkg::S_LINK:
            begin
                u_we    = 1'b1;
                u_waddr = child_reg;
                u_wdata = {root_reg, SZ_W'(1)};
            end
            kmst_pkg::S_GROW:
            begin
                u_we    = 1'b1;
                u_waddr = root_reg;
                u_wdata = {root_reg, nsize_reg};
            end
            default:
                u_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmst_pkg::S_LOAD;
            vcount_reg    <= kmst_pkg::VCOUNT_RESET;
            fill_reg      <= '0;
            drop_full_reg <= 1'b0;
            drop_bad_reg  <= 1'b0;
            init_reg      <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;

            rd_vld_reg <= scan_rd;
            rd_idx_reg <= scan_reg[EA-1:0];
            if (scan_rd)
                scan_reg <= scan_reg + FILL_W'(1);

            if ((state_reg == kmst_pkg::S_DONE) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                kmst_pkg::S_LOAD:
                    if (in_acc)
                    begin
                        if (bad)
                            drop_bad_reg <= 1'b1;
                        else if (full)
                            drop_full_reg <= 1'b1;
                        else
                            fill_reg <= fill_reg + FILL_W'(1);
                        init_reg      <= '0;
                        scan_reg      <= '0;
                        found_reg     <= 1'b0;
                        have_prev_reg <= 1'b0;
                        acc_reg       <= '0;
                    end
                kmst_pkg::S_INIT:
                    init_reg <= init_reg + VB'(1);
                kmst_pkg::S_SCAN:
                begin
                    if (rd_vld_reg && cand_ok)
                    begin
                        found_reg    <= 1'b1;
                        best_w_reg   <= rd_w;
                        best_i_reg   <= rd_idx_reg;
                        best_src_reg <= rd_src;
                        best_dst_reg <= rd_dst;
                    end
                    if (round_end && found_reg)
                    begin
                        have_prev_reg <= 1'b1;
                        prev_w_reg    <= best_w_reg;
                        prev_i_reg    <= best_i_reg;
                        cur_reg       <= best_src_reg;
                    end
                end
                kmst_pkg::S_CHKA:
                    if (par == cur_reg)
                    begin
                        ra_reg  <= cur_reg;
                        sa_reg  <= sz;
                        cur_reg <= best_dst_reg;
                    end
                    else
                        cur_reg <= par;
                kmst_pkg::S_CHKB:
                    if (par != cur_reg)
                        cur_reg <= par;
                    else
                    begin
                        // next round starts from slot zero
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        if (!same_root)
                        begin
                            acc_reg   <= acc_reg + ACC_W'(best_w_reg);
                            nsize_reg <= sa_reg + sz;
                            if (sa_reg < sz)
                            begin
                                child_reg <= ra_reg;
                                root_reg  <= cur_reg;
                            end
                            else
                            begin
                                child_reg <= cur_reg;
                                root_reg  <= ra_reg;
                            end
                        end
                    end
                kmst_pkg::S_DONE:
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg.tree_weight        <= sat_sum;
                        out_data_reg.edges_dropped_full <= drop_full_reg;
                        out_data_reg.edges_dropped_bad  <= drop_bad_reg;
                        fill_reg                        <= '0;
                        drop_full_reg                   <= 1'b0;
                        drop_bad_reg                    <= 1'b0;
                    end
                default:
                    scan_reg <= scan_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_EDGES))
        else $error("edge fill above capacity");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.last_edge) |=> in_stall)
        else $error("input not stalled after last edge");

    a_no_uf_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmst_pkg::S_SCAN) |-> !u_we)
        else $error("union-find write during scan");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == kmst_pkg::S_DONE))
        else $error("result posted outside done state");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kruskal_mst_weight. A directed table of graphs comes
// first, then random graphs of mostly small size. A few graphs are large, and
// one overflows the edge store. Each result is compared with the typed value
// from the table or with a spanning forest predictor. Both sides idle and stall
// at random, and vertex_count is reprogrammed between and within graphs.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NV       = 64;
    localparam int NE       = 256;
    localparam int WDOG_MAX = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    kmst_pkg::edge_in_t    in_data;
    logic                  out_valid;
    logic                  out_stall;
    kmst_pkg::forest_out_t out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [6:0]            cfg_data;

    kruskal_mst_weight DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [5:0]         held_src [NE];
    logic [5:0]         held_dst [NE];
    logic signed [15:0] held_w   [NE];
    int                 held_fill;
    bit                 saw_full;
    bit                 saw_bad;
    logic [6:0]         vcount;

    kmst_pkg::forest_out_t forest_q[$];
    int          errors;
    int          idle_cycles;

    typedef struct {
        int vc;
        int src;
        int dst;
        int w;
        bit last;
        bit chk;
        int tw;
        bit full;
        bit bad;
    } edge_row_t;

    edge_row_t rows[] = '{
        // self loop adds nothing
        '{64, 0, 0, 5, 1, 1, 0, 0, 0},
        '{64, 0, 63, -32768, 1, 1, -32768, 0, 0},
        '{64, 63, 0, 32767, 1, 1, 32767, 0, 0},
        '{64, 1, 2, 3, 0, 0, 0, 0, 0},
        '{64, 2, 3, 4, 0, 0, 0, 0, 0},
        '{64, 1, 3, 1, 1, 1, 4, 0, 0},
        // endpoint at the limit: empty graph with the bad flag
        '{10, 10, 0, 7, 1, 1, 0, 0, 1},
        '{10, 9, 0, -3, 0, 0, 0, 0, 0},
        '{10, 0, 12, 9, 0, 0, 0, 0, 0},
        '{10, 8, 9, 2, 1, 0, 0, 0, 0},
        '{0, 0, 0, 1, 1, 1, 0, 0, 1},
        '{127, 63, 62, -1, 1, 1, -1, 0, 0},
        '{1, 0, 0, -5, 1, 1, 0, 0, 0},
        '{2, 1, 0, -7, 1, 1, -7, 0, 0},
        '{64, 5, 6, 100, 0, 0, 0, 0, 0},
        '{64, 6, 7, 100, 0, 0, 0, 0, 0},
        '{64, 5, 7, 100, 1, 1, 200, 0, 0},
        '{64, 40, 41, -32768, 0, 0, 0, 0, 0},
        '{64, 41, 42, 32767, 0, 0, 0, 0, 0},
        '{64, 40, 42, 0, 0, 0, 0, 0, 0},
        '{64, 42, 40, 5, 1, 0, 0, 0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Kruskal over the held edges: stable sort by weight, union by size
    function automatic kmst_pkg::forest_out_t forest_weight();
        logic [5:0]         s_src [NE];
        logic [5:0]         s_dst [NE];
        logic signed [15:0] s_w   [NE];
        int                 parent[NV];
        int                 csize [NV];
        logic [5:0]         ks;
        logic [5:0]         kd;
        logic signed [15:0] kw;
        int                 j;
        int                 ra;
        int                 rb;
        longint             sum;
        kmst_pkg::forest_out_t r;
        sum = 0;
        for (int i = 0; i < held_fill; i++)
        begin
            s_src[i] = held_src[i];
            s_dst[i] = held_dst[i];
            s_w[i]   = held_w[i];
        end
        for (int i = 1; i < held_fill; i++)
        begin
            ks = s_src[i];
            kd = s_dst[i];
            kw = s_w[i];
            j  = i;
            while (j > 0 && s_w[j-1] > kw)
            begin
                s_src[j] = s_src[j-1];
                s_dst[j] = s_dst[j-1];
                s_w[j]   = s_w[j-1];
                j--;
            end
            s_src[j] = ks;
            s_dst[j] = kd;
            s_w[j]   = kw;
        end
        for (int i = 0; i < NV; i++)
        begin
            parent[i] = i;
            csize[i]  = 1;
        end
        for (int i = 0; i < held_fill; i++)
        begin
            ra = s_src[i];
            rb = s_dst[i];
            while (parent[ra] != ra)
                ra = parent[ra];
            while (parent[rb] != rb)
                rb = parent[rb];
            if (ra != rb)
            begin
                sum += s_w[i];
                if (csize[ra] < csize[rb])
                begin
                    parent[ra] = rb;
                    csize[rb] += csize[ra];
                end
                else
                begin
                    parent[rb] = ra;
                    csize[ra] += csize[rb];
                end
            end
        end
        if (sum > 2097151)
            sum = 2097151;
        if (sum < -2097152)
            sum = -2097152;
        r.tree_weight        = sum[21:0];
        r.edges_dropped_full = saw_full;
        r.edges_dropped_bad  = saw_bad;
        return r;
    endfunction

    // returns 1 when the edge closes a graph; res then holds the prediction
    function automatic bit absorb_edge(kmst_pkg::edge_in_t d,
                                       output kmst_pkg::forest_out_t res);
        int lim;
        lim = (vcount < NV) ? vcount : NV;
        res = '0;
        if (d.edge_src >= lim || d.edge_dst >= lim)
            saw_bad = 1'b1;
        else if (held_fill >= NE)
            saw_full = 1'b1;
        else
        begin
            held_src[held_fill] = d.edge_src;
            held_dst[held_fill] = d.edge_dst;
            held_w[held_fill]   = d.edge_weight;
            held_fill++;
        end
        if (!d.last_edge)
            return 1'b0;
        res       = forest_weight();
        held_fill = 0;
        saw_full  = 1'b0;
        saw_bad   = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_edge(kmst_pkg::edge_in_t d, bit chk, kmst_pkg::forest_out_t typed);
        int                    gap;
        kmst_pkg::forest_out_t res;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (in_stall);
        if (absorb_edge(d, res))
            forest_q = {forest_q, (chk ? typed : res)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (forest_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_vcount(logic [6:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        vcount = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [5:0] pick_end(int lim);
        if (lim == 0 || $urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [6:0] pick_vcount();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 7'd0;
        if (r == 1)
            return 7'd127;
        if (r == 2)
            return 7'd64;
        if (r == 3)
            return 7'($urandom_range(1, 3));
        return 7'($urandom_range(8, 127));
    endfunction

    // receiver
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            gap = pick_gap();
            @(negedge clk);
            out_stall <= (gap != 0);
            repeat (gap)
                @(negedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        kmst_pkg::forest_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (forest_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                want = forest_q.pop_front();
                if (out_data.tree_weight !== want.tree_weight)
                    report("tree_weight", out_data.tree_weight, want.tree_weight);
                if (out_data.edges_dropped_full !== want.edges_dropped_full)
                    report("edges_dropped_full", out_data.edges_dropped_full,
                           want.edges_dropped_full);
                if (out_data.edges_dropped_bad !== want.edges_dropped_bad)
                    report("edges_dropped_bad", out_data.edges_dropped_bad,
                           want.edges_dropped_bad);
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("kruskal_mst_weight test failed");
            $finish;
        end
    end

    initial
    begin
        kmst_pkg::edge_in_t    d;
        kmst_pkg::forest_out_t typed;
        int          n_items;
        int          gsize;
        int          lim;
        int          big_done;
        held_fill   = 0;
        saw_full    = 0;
        saw_bad     = 0;
        vcount      = kmst_pkg::VCOUNT_RESET;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].vc != vcount)
                write_vcount(7'(rows[i].vc));
            d.edge_src          = 6'(rows[i].src);
            d.edge_dst          = 6'(rows[i].dst);
            d.edge_weight       = 16'(rows[i].w);
            d.last_edge         = rows[i].last;
            typed.tree_weight   = 22'(rows[i].tw);
            typed.edges_dropped_full = rows[i].full;
            typed.edges_dropped_bad  = rows[i].bad;
            send_edge(d, rows[i].chk, typed);
        end

        n_items  = 0;
        big_done = 0;
        typed    = '0;
        while (n_items < 1250)
        begin
            if ($urandom_range(0, 3) == 0)
                write_vcount(pick_vcount());
            if (big_done == 0 && n_items > 500)
            begin
                gsize    = $urandom_range(NE + 5, NE + 40);
                big_done = 1;
            end
            else if ($urandom_range(0, 19) == 0)
                gsize = $urandom_range(30, 70);
            else
                gsize = $urandom_range(1, 12);
            for (int k = 0; k < gsize; k++)
            begin
                // occasional change of the limit while a graph is loading
                if (k == gsize / 2 && gsize > 3 && $urandom_range(0, 7) == 0)
                    write_vcount(pick_vcount());
                lim           = (vcount < NV) ? vcount : NV;
                d.edge_src    = pick_end(lim);
                d.edge_dst    = pick_end(lim);
                d.edge_weight = 16'($urandom_range(0, 65535));
                d.last_edge   = (k == gsize - 1);
                send_edge(d, 1'b0, typed);
                n_items++;
            end
        end

        wait_drained();
        repeat (100)
            @(posedge clk);
        if (errors == 0)
            $display("kruskal_mst_weight test passed");
        else
            $display("kruskal_mst_weight test failed");
        $finish;
    end

endmodule
